/* hdl/pnd_pkg.sv */
// Shared types and constants for the palette nearest-color dither block.
// Used by pnd_dist, palette_nearest_color_dither_core and the bench; no dependencies.
`default_nettype none

package pnd_pkg;

  // Operation codes carried by each input item.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_DITHER = 2'd3;

  // Bayer 4x4 matrix, indexed by {row, col}.
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd12, 4'd3,  4'd15,
    4'd8,  4'd4,  4'd11, 4'd7,
    4'd2,  4'd14, 4'd1,  4'd13,
    4'd10, 4'd6,  4'd9,  4'd5
  };

  // One palette entry handed from the cell chain to the distance unit.
  typedef struct packed {
    logic        valid;
    logic        first;
    logic        last;
    logic [7:0]  idx;
    logic [23:0] entry;
  } pnd_feed_t;

  // Dither offset for Bayer value k; evaluated at elaboration only.
  // Rounds half away from zero by finding the largest quotient that fits.
  function automatic int dither_offset(int k, int color_bits);
    int n;
    int mag;
    int m;
    int lhs;
    int q;
    n   = k - 8;
    mag = (n < 0) ? -n : n;
    m   = (1 << color_bits) - 1;
    lhs = 2 * 17085 * mag + 160 * m;
    q   = 0;
    for (int t = 0; t < 1024; t++) begin
      if (t * 320 * m <= lhs) q = t;
    end
    return (n < 0) ? -q : q;
  endfunction

endpackage

`default_nettype wire

/* hdl/palette_nearest_color_dither_core.sv */
// Palette with nearest-color search and 4x4 ordered dither; uses pnd_pkg, pnd_cell, pnd_dist.
// Write and read of a present entry finish when it reaches the chain head; write or read of
// an absent entry finishes at acceptance. Search waits for entry 0 at the head, then scans
// every entry through the distance unit; dither first seeks its source, then searches.
// One item at a time; the next is taken after the result leaves.
// Synchronous active-low reset clears every palette entry to zero at once.
`default_nettype none

module palette_nearest_color_dither_core
  import pnd_pkg::*;
#(
  parameter int COLOR_BITS      = 7,
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op[1:0], entry_index[9:2], red_in[17:10], green_in[25:18], blue_in[33:26],
  // pixel_col[35:34], pixel_row[37:36], zero pad [39:38]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_index[7:0], red_out[15:8], green_out[23:16], blue_out[31:24]
  output logic      [31:0] out_tdata
);

  localparam int N  = PALETTE_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int SH = 8 - COLOR_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEEK = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [IW-1:0] ptr_r;
  logic [1:0]  op_r;
  logic [7:0]  idx_r;
  logic [23:0] wdata_r;
  logic [3:0]  bay_r;
  logic [23:0] q_r, q_nxt;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [23:0] cell_q [N];
  logic [23:0] tail_d;
  logic        hit, wr_en, idx_ok;
  logic signed [11:0] off_tab [16];
  logic signed [11:0] off;
  logic [23:0] src;
  logic [23:0] dith;
  pnd_feed_t   feed;
  logic        dist_done;
  logic [7:0]  dist_best;

  logic [1:0] in_op;
  logic [7:0] in_idx;
  logic [23:0] in_rgb;
  logic [3:0] in_bay;
  logic in_acc;

  assign in_op  = in_tdata[1:0];
  assign in_idx = in_tdata[9:2];
  assign in_rgb = in_tdata[33:10];
  assign in_bay = {in_tdata[37:36], in_tdata[35:34]};
  assign in_acc = in_tvalid && in_tready;

  // Offsets per Bayer value, fixed at elaboration.
  for (genvar k = 0; k < 16; k++) begin : g_off
    assign off_tab[k] = 12'(dither_offset(k, COLOR_BITS));
  end

  function automatic logic [7:0] quant(input logic [7:0] c);
    return 8'((c >> SH) << SH);
  endfunction

  function automatic logic [7:0] clamp_add(input logic [7:0] c,
                                           input logic signed [11:0] o);
    logic signed [12:0] v;
    v = $signed({5'b0, c}) + 13'(o);
    if (v < 0) return 8'd0;
    if (v > 13'sd255) return 8'd255;
    return v[7:0];
  endfunction

  // Rotating chain of palette cells; entry ptr_r sits at the head.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      pnd_cell u_cell (.clk(clk), .rst_n(rst_n), .d_i(tail_d), .q_o(cell_q[i]));
    end else begin : g_body
      pnd_cell u_cell (.clk(clk), .rst_n(rst_n), .d_i(cell_q[i+1]), .q_o(cell_q[i]));
    end
  end

  assign idx_ok = 9'(idx_r) < 9'(N);
  assign hit    = (state_r == S_SEEK) && (ptr_r == idx_r[IW-1:0]);
  assign wr_en  = hit && (op_r == OP_WRITE);
  assign tail_d = wr_en ? wdata_r : cell_q[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (ptr_r == IW'(N - 1)) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // Dithered source color, quantized for the search.
  assign off  = off_tab[bay_r];
  assign src  = (hit && idx_ok) ? cell_q[0] : 24'd0;
  assign dith = {quant(clamp_add(src[23:16], off)), quant(clamp_add(src[15:8], off)),
                 quant(clamp_add(src[7:0], off))};

  // Feed the head entry to the distance unit during the scan.
  always_comb begin
    feed.valid = (state_r == S_SCAN);
    feed.first = (ptr_r == '0);
    feed.last  = (ptr_r == IW'(N - 1));
    feed.idx   = 8'(ptr_r);
    feed.entry = cell_q[0];
  end

  pnd_dist u_dist (
    .clk(clk), .rst_n(rst_n), .feed_i(feed), .color_i(q_r),
    .done_o(dist_done), .best_o(dist_best)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_SEARCH) begin
            state_nxt = S_WAIT;
            q_nxt = {quant(in_rgb[23:16]), quant(in_rgb[15:8]), quant(in_rgb[7:0])};
          end else if (9'(in_idx) < 9'(N)) begin
            state_nxt = S_SEEK;
          end else if (in_op == OP_DITHER) begin
            state_nxt = S_SEEK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SEEK: begin
        if (!idx_ok) begin
          q_nxt = dith;
          state_nxt = S_WAIT;
        end else if (hit) begin
          if (op_r == OP_DITHER) begin
            q_nxt = dith;
            state_nxt = S_WAIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WAIT: begin
        if (ptr_r == IW'(N - 1)) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (ptr_r == IW'(N - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (dist_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      // Results that finish at acceptance: write or read of an absent entry.
      if (in_acc && in_op != OP_SEARCH && in_op != OP_DITHER && !(9'(in_idx) < 9'(N))) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_SEEK && idx_ok && hit && op_r != OP_DITHER) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_DONE && dist_done) out_valid_r <= 1'b1;
    end
  end

  // Item fields and result payload.
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (in_acc) begin
      op_r    <= in_op;
      idx_r   <= in_idx;
      wdata_r <= {in_rgb[23:16], in_rgb[15:8], in_rgb[7:0]};
      bay_r   <= BAYER[in_bay];
      out_data_r <= {24'd0, in_idx};
    end
    if (state_r == S_SEEK && idx_ok && hit && op_r == OP_READ) begin
      out_data_r <= {cell_q[0], idx_r};
    end
    if (state_r == S_DONE && dist_done) begin
      out_data_r <= {24'd0, dist_best};
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* hdl/pnd_cell.sv */
// One storage cell of the rotating palette chain: holds a 24-bit entry.
// Depends on nothing; instantiated by palette_nearest_color_dither_core.
`default_nettype none

module pnd_cell (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [23:0] d_i,
  output logic      [23:0] q_o
);

  logic [23:0] ent_r;

  // The entry moves one place toward the head every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= d_i;
    end
  end

  assign q_o = ent_r;

endmodule

`default_nettype wire

/* hdl/pnd_dist.sv */
// Distance unit: squared RGB distance per entry and running minimum.
// Depends on pnd_pkg; fed one entry per cycle from the head of the chain.
`default_nettype none

module pnd_dist
  import pnd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pnd_feed_t   feed_i,
  input  wire logic [23:0] color_i,
  output logic             done_o,
  output logic      [7:0]  best_o
);

  logic signed [8:0]  dr, dg, db;
  logic signed [17:0] pr, pg, pb;
  logic [15:0] sqr_r, sqg_r, sqb_r;
  logic        v1_r, first1_r, last1_r;
  logic [7:0]  idx1_r;
  logic [17:0] sum;
  logic [17:0] best_d_r;
  logic [7:0]  best_i_r;
  logic        done_r;

  // Channel differences and their squares.
  always_comb begin
    dr = $signed({1'b0, feed_i.entry[7:0]})   - $signed({1'b0, color_i[7:0]});
    dg = $signed({1'b0, feed_i.entry[15:8]})  - $signed({1'b0, color_i[15:8]});
    db = $signed({1'b0, feed_i.entry[23:16]}) - $signed({1'b0, color_i[23:16]});
    pr = dr * dr;
    pg = dg * dg;
    pb = db * db;
  end

  // Stage one registers the squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= feed_i.valid;
    end
    first1_r <= feed_i.first;
    last1_r  <= feed_i.last;
    idx1_r   <= feed_i.idx;
    sqr_r    <= pr[15:0];
    sqg_r    <= pg[15:0];
    sqb_r    <= pb[15:0];
  end

  assign sum = 18'(sqr_r) + 18'(sqg_r) + 18'(sqb_r);

  // Stage two keeps the smallest distance; a tie keeps the earlier index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r   <= 1'b0;
      best_d_r <= '0;
      best_i_r <= '0;
    end else begin
      done_r <= v1_r && last1_r;
      if (v1_r) begin
        if (first1_r || (sum < best_d_r)) begin
          best_d_r <= sum;
          best_i_r <= idx1_r;
        end
      end
    end
  end

  assign done_o = done_r;
  assign best_o = best_i_r;

endmodule

`default_nettype wire

/* sim/tb_palette_nearest_color_dither_core.sv */
// Self-checking bench for palette_nearest_color_dither_core: a queue-fed driver,
// a monitor and a local palette predictor for write, read, search and dither.
// Depends on pnd_pkg and the core RTL.
`default_nettype none

module tb_palette_nearest_color_dither_core;
  import pnd_pkg::*;

  localparam int COLOR_BITS = 7;
  localparam int ENTRIES    = 256;
  localparam int CH_SHIFT   = 8 - COLOR_BITS;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] idx;
    logic [1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] idx;
  } resp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  palette_nearest_color_dither_core #(
    .COLOR_BITS(COLOR_BITS),
    .PALETTE_ENTRIES(ENTRIES)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Predictor state.
  logic [7:0] pal_red [ENTRIES];
  logic [7:0] pal_green [ENTRIES];
  logic [7:0] pal_blue [ENTRIES];
  int         bayer_k [4][4] = '{'{0, 12, 3, 15}, '{8, 4, 11, 7},
                                 '{2, 14, 1, 13}, '{10, 6, 9, 5}};

  cmd_t  pending_cmds[$];
  resp_t expected_resps[$];
  bit    failed;
  bit    stim_done;
  bit    pause_for_drain;
  int    long_hold;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic int offset_for(int k);
    int n, mag, num, den, q;
    n   = k - 8;
    mag = (n < 0) ? -n : n;
    num = 17085 * mag;
    den = 160 * ((1 << COLOR_BITS) - 1);
    q   = (2 * num + den) / (2 * den);
    return (n < 0) ? -q : q;
  endfunction

  function automatic int clamp_channel(int c, int off);
    int v;
    v = c + off;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic logic [7:0] nearest_entry(int r, int g, int b);
    int qr, qg, qb, dr, dg, db;
    longint d, best_d;
    logic [7:0] best;
    qr = (r >> CH_SHIFT) << CH_SHIFT;
    qg = (g >> CH_SHIFT) << CH_SHIFT;
    qb = (b >> CH_SHIFT) << CH_SHIFT;
    best = 0;
    best_d = 64'h7fffffff_ffffffff;
    for (int i = 0; i < ENTRIES; i++) begin
      dr = int'(pal_red[i]) - qr;
      dg = int'(pal_green[i]) - qg;
      db = int'(pal_blue[i]) - qb;
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best = i[7:0];
      end
    end
    return best;
  endfunction

  // Applies one accepted command to the palette copy and queues its response.
  function automatic void predict_response(cmd_t c);
    resp_t r;
    bit    ok;
    int    off, sr, sg, sb;
    ok = int'(c.idx) < ENTRIES;
    r = '0;
    r.idx = c.idx;
    case (c.op)
      OP_WRITE: begin
        if (ok) begin
          pal_red[c.idx] = c.red;
          pal_green[c.idx] = c.green;
          pal_blue[c.idx] = c.blue;
        end
      end
      OP_READ: begin
        if (ok) begin
          r.red = pal_red[c.idx];
          r.green = pal_green[c.idx];
          r.blue = pal_blue[c.idx];
        end
      end
      OP_SEARCH: begin
        r.idx = nearest_entry(c.red, c.green, c.blue);
      end
      default: begin
        sr = ok ? pal_red[c.idx] : 0;
        sg = ok ? pal_green[c.idx] : 0;
        sb = ok ? pal_blue[c.idx] : 0;
        off = offset_for(bayer_k[c.row][c.col]);
        r.idx = nearest_entry(clamp_channel(sr, off), clamp_channel(sg, off),
                              clamp_channel(sb, off));
      end
    endcase
    expected_resps.push_back(r);
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] op, int idx, int r, int g, int b,
                                    int col, int row);
    cmd_t c;
    c.op = op; c.idx = 8'(idx); c.red = 8'(r); c.green = 8'(g); c.blue = 8'(b);
    c.col = 2'(col); c.row = 2'(row);
    return c;
  endfunction

  // Random channel value biased toward the extremes.
  function automatic int rand_channel();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Driver: offers one pending command at a time, with random gaps.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
      // Hold the offered item.
    end else begin
      // The accepted item leaves the queue, so the next one is always at the front.
      if (in_tvalid) begin
        predict_response(cmd_t'(in_tdata[37:0]));
        void'(pending_cmds.pop_front());
      end
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pause_for_drain && expected_resps.size() != 0 ||
                   pause_for_drain && in_tvalid) begin
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, pending_cmds[0]};
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted response against the oldest prediction.
  int recv_gap;
  always @(posedge clk) begin
    resp_t got, want;
    int    gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_resps.size() == 0) begin
          $error("unexpected response %h", out_tdata);
          failed = 1'b1;
        end else begin
          want = expected_resps.pop_front();
          if (got.idx !== want.idx) begin
            $error("result_index: expected %0d, got %0d", want.idx, got.idx);
            failed = 1'b1;
          end
          if (got.red !== want.red) begin
            $error("red_out: expected %0d, got %0d", want.red, got.red);
            failed = 1'b1;
          end
          if (got.green !== want.green) begin
            $error("green_out: expected %0d, got %0d", want.green, got.green);
            failed = 1'b1;
          end
          if (got.blue !== want.blue) begin
            $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
            failed = 1'b1;
          end
        end
      end
      if (long_hold > 0) begin
        out_tready <= 1'b0;
        long_hold <= long_hold - 1;
      end else if (recv_gap > 0) begin
        out_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (out_tvalid && out_tready) begin
        // Draw the wait before the next item; no wait keeps ready high.
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        recv_gap <= gap;
        out_tready <= (gap == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corners first, then random traffic.
  initial begin
    int idx;
    failed = 1'b0;
    stim_done = 1'b0;
    pause_for_drain = 1'b0;
    long_hold = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      pal_red[i] = 0; pal_green[i] = 0; pal_blue[i] = 0;
    end
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset palette: read and search over all-zero entries.
    pending_cmds.push_back(make_cmd(OP_READ, 255, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 0, 255, 255, 255, 3, 3));
    pending_cmds.push_back(make_cmd(OP_WRITE, 0, 255, 255, 255, 0, 0));
    pending_cmds.push_back(make_cmd(OP_WRITE, 255, 0, 0, 0, 3, 3));
    pending_cmds.push_back(make_cmd(OP_WRITE, 1, 128, 0, 255, 1, 2));
    pending_cmds.push_back(make_cmd(OP_WRITE, 2, 1, 1, 1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_WRITE, 3, 254, 254, 254, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ, 1, 255, 255, 255, 3, 3));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 7, 1, 1, 1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 7, 255, 255, 255, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 7, 129, 1, 254, 0, 0));
    // Dither from white and black at both Bayer extremes, then from near-black, near-white and a mid color.
    pending_cmds.push_back(make_cmd(OP_DITHER, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DITHER, 0, 0, 0, 0, 3, 0));
    pending_cmds.push_back(make_cmd(OP_DITHER, 255, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DITHER, 255, 0, 0, 0, 3, 0));
    pending_cmds.push_back(make_cmd(OP_DITHER, 2, 0, 0, 0, 2, 2));
    pending_cmds.push_back(make_cmd(OP_DITHER, 3, 0, 0, 0, 3, 3));
    pending_cmds.push_back(make_cmd(OP_DITHER, 1, 0, 0, 0, 1, 1));
    // Duplicate colors: tie goes to the lower index.
    pending_cmds.push_back(make_cmd(OP_WRITE, 200, 255, 255, 255, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 9, 255, 255, 255, 2, 1));

    // Fill the block while the receiver holds off.
    for (int i = 0; i < 8; i++)
      pending_cmds.push_back(make_cmd(OP_WRITE, 10 + i, rand_channel(), rand_channel(),
                                      rand_channel(), i % 4, i / 4));
    wait (pending_cmds.size() <= 8);
    long_hold = 2000;
    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);

    // Random part: mostly writes and searches, with reads and dithers.
    for (int n = 0; n < 1330; n++) begin
      idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31);
      if (n == 600) begin
        wait (pending_cmds.size() == 0);
        pause_for_drain = 1'b1;
        wait (expected_resps.size() == 0 && !in_tvalid);
        pause_for_drain = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: pending_cmds.push_back(make_cmd(OP_WRITE, idx, rand_channel(),
                    rand_channel(), rand_channel(), $urandom_range(0, 3),
                    $urandom_range(0, 3)));
        3: pending_cmds.push_back(make_cmd(OP_READ, idx, rand_channel(), rand_channel(),
                    rand_channel(), $urandom_range(0, 3), $urandom_range(0, 3)));
        4, 5, 6: pending_cmds.push_back(make_cmd(OP_SEARCH, $urandom_range(0, 255),
                    rand_channel(), rand_channel(), rand_channel(),
                    $urandom_range(0, 3), $urandom_range(0, 3)));
        default: pending_cmds.push_back(make_cmd(OP_DITHER, idx, rand_channel(),
                    rand_channel(), rand_channel(), $urandom_range(0, 3),
                    $urandom_range(0, 3)));
      endcase
      if (pending_cmds.size() > 16) wait (pending_cmds.size() <= 4);
    end

    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
    repeat (2 * ENTRIES + 20) @(posedge clk);
    if (!failed && expected_resps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: bounds a run of about 1360 items with both sides idling.
  initial begin
    #(8 * 6000000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
